// ===== design/rsrb_pkg.sv =====
// Shared types, codes and helpers for the RTP sequence reorder buffer.
// No dependencies; rsrb_cell, the top level and the checker use this package.
`timescale 1ns / 1ps
`default_nettype none

package rsrb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_IN_ORDER  = 3'd3,
    ST_LOSS      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FLUSHED   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC
  } fsm_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_LOAD_NEW,
    CELL_LOAD_LEFT,
    CELL_LOAD_RIGHT
  } cell_action_t;

  typedef struct packed {
    cell_action_t action;
    logic         occ;
  } cell_ctrl_t;

  // Half-range wraparound order: a precedes b.
  function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] diff;
    diff = a - b;
    return diff[15];
  endfunction

endpackage

`default_nettype wire

// ===== design/rsrb_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rsrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] seq_num;
  logic [15:0] tag;

  modport source (output valid, output opcode, output seq_num, output tag, input ready);
  modport sink   (input valid, input opcode, input seq_num, input tag, output ready);
endinterface

interface rsrb_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_seq_num;
  logic [15:0] out_tag;
  logic [15:0] lost_count;
  logic [31:0] lost_total_out;

  modport source (output valid, output status, output out_seq_num, output out_tag,
                  output lost_count, output lost_total_out, input ready);
  modport sink   (input valid, input status, input out_seq_num, input out_tag,
                  input lost_count, input lost_total_out, output ready);
endinterface

`default_nettype wire

// ===== design/rsrb_cell.sv =====
// One entry of the sorted chain: holds a sequence number and tag, compares
// against the broadcast key and shifts to/from its neighbors. Uses rsrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsrb_cell (
  input  wire logic                clk,
  input  wire rsrb_pkg::cell_ctrl_t ctrl,
  input  wire logic [15:0]         key,
  input  wire logic [15:0]         key_tag,
  input  wire logic [15:0]         left_seq,
  input  wire logic [15:0]         left_tag,
  input  wire logic [15:0]         right_seq,
  input  wire logic [15:0]         right_tag,
  output logic      [15:0]         seq,
  output logic      [15:0]         tag,
  output logic                     hit,
  output logic                     bf
);

  always_ff @(posedge clk) begin
    case (ctrl.action)
      rsrb_pkg::CELL_CMP: begin
        hit <= ctrl.occ && (seq == key);
        bf  <= ctrl.occ && rsrb_pkg::seq_before(key, seq);
      end
      rsrb_pkg::CELL_LOAD_NEW: begin
        seq <= key;
        tag <= key_tag;
      end
      rsrb_pkg::CELL_LOAD_LEFT: begin
        seq <= left_seq;
        tag <= left_tag;
      end
      rsrb_pkg::CELL_LOAD_RIGHT: begin
        seq <= right_seq;
        tag <= right_tag;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rtp_sequence_reorder_buffer_unit.sv =====
// RTP sequence reorder buffer top level: control FSM plus a row of rsrb_cell.
// Depends on rsrb_pkg, rsrb_if and rsrb_cell.
//
// A request is first captured, then every cell compares its entry with the
// sequence number in parallel, then the duplicate check, insert position and
// the shift of the chain (or the pop from the head, or the flush) happen in
// the decide state. A new request is accepted while the previous result still
// waits on the output register; the decide cycle stalls only if that register
// is still full. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rtp_sequence_reorder_buffer_unit #(
  parameter int unsigned DEPTH = rsrb_pkg::DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  rsrb_req_if.sink     request,
  rsrb_res_if.source   result
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rsrb_pkg::fsm_t state, state_next;

  logic [1:0]       op;
  logic [15:0]      key;
  logic [15:0]      key_tag;
  logic [CNT_W-1:0] fill, fill_next;
  logic [15:0]      expected, expected_next;
  logic             seen_first, seen_first_next;
  logic [31:0]      lost_total, lost_total_next;

  logic             out_valid, out_valid_next;
  rsrb_pkg::status_t out_status, out_status_next;
  logic [15:0]      out_seq, out_seq_next;
  logic [15:0]      out_tag, out_tag_next;
  logic [15:0]      out_lost, out_lost_next;

  logic [15:0]      cell_seq [DEPTH];
  logic [15:0]      cell_tag [DEPTH];
  logic [DEPTH-1:0] hit_v;
  logic [DEPTH-1:0] bf_v;
  logic [DEPTH-1:0] shift_le;
  logic [DEPTH-1:0] shift_up;
  rsrb_pkg::cell_ctrl_t ctrl [DEPTH];

  logic dup, full, fire, do_ins, do_pop;

  assign request.ready         = (state == rsrb_pkg::S_IDLE);
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.out_seq_num    = out_seq;
  assign result.out_tag        = out_tag;
  assign result.lost_count     = out_lost;
  assign result.lost_total_out = lost_total;

  assign dup      = |hit_v;
  assign full     = (fill == CNT_W'(DEPTH));
  // Ones from the first cell whose entry follows the key upward.
  assign shift_le = bf_v | (DEPTH'(0) - bf_v);
  assign shift_up = shift_le << 1;
  assign fire     = (state == rsrb_pkg::S_DEC) && (!out_valid || result.ready);
  assign do_ins   = fire && (op == rsrb_pkg::OP_INSERT) && !dup && !full;
  assign do_pop   = fire && (op == rsrb_pkg::OP_POP) && (fill != '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].occ    = (CNT_W'(i) < fill);
      ctrl[i].action = rsrb_pkg::CELL_HOLD;
      if (state == rsrb_pkg::S_CMP) begin
        ctrl[i].action = rsrb_pkg::CELL_CMP;
      end else if (do_pop) begin
        ctrl[i].action = rsrb_pkg::CELL_LOAD_RIGHT;
      end else if (do_ins) begin
        if (shift_up[i]) begin
          ctrl[i].action = rsrb_pkg::CELL_LOAD_LEFT;
        end else if (shift_le[i] || (CNT_W'(i) == fill)) begin
          ctrl[i].action = rsrb_pkg::CELL_LOAD_NEW;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [15:0] l_seq, l_tag, r_seq, r_tag;
    if (g == 0) begin : g_first
      assign l_seq = key;
      assign l_tag = key_tag;
    end else begin : g_mid
      assign l_seq = cell_seq[g-1];
      assign l_tag = cell_tag[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign r_seq = cell_seq[g];
      assign r_tag = cell_tag[g];
    end else begin : g_inner
      assign r_seq = cell_seq[g+1];
      assign r_tag = cell_tag[g+1];
    end
    rsrb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .key       (key),
      .key_tag   (key_tag),
      .left_seq  (l_seq),
      .left_tag  (l_tag),
      .right_seq (r_seq),
      .right_tag (r_tag),
      .seq       (cell_seq[g]),
      .tag       (cell_tag[g]),
      .hit       (hit_v[g]),
      .bf        (bf_v[g])
    );
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    expected_next   = expected;
    seen_first_next = seen_first;
    lost_total_next = lost_total;
    out_valid_next  = out_valid && !result.ready;
    out_status_next = out_status;
    out_seq_next    = out_seq;
    out_tag_next    = out_tag;
    out_lost_next   = out_lost;
    case (state)
      rsrb_pkg::S_IDLE: begin
        if (request.valid) begin
          state_next = rsrb_pkg::S_CMP;
        end
      end
      rsrb_pkg::S_CMP: begin
        state_next = rsrb_pkg::S_DEC;
      end
      rsrb_pkg::S_DEC: begin
        if (fire) begin
          state_next      = rsrb_pkg::S_IDLE;
          out_valid_next  = 1'b1;
          out_status_next = rsrb_pkg::ST_EMPTY;
          out_seq_next    = '0;
          out_tag_next    = '0;
          out_lost_next   = '0;
          case (op)
            rsrb_pkg::OP_INSERT: begin
              if (!seen_first) begin
                seen_first_next = 1'b1;
                expected_next   = key;
              end
              if (dup) begin
                out_status_next = rsrb_pkg::ST_DUPLICATE;
              end else if (full) begin
                out_status_next = rsrb_pkg::ST_FULL;
              end else begin
                out_status_next = rsrb_pkg::ST_INSERTED;
                fill_next       = fill + CNT_W'(1);
              end
            end
            rsrb_pkg::OP_POP: begin
              if (fill != '0) begin
                out_seq_next = cell_seq[0];
                out_tag_next = cell_tag[0];
                fill_next    = fill - CNT_W'(1);
                if (cell_seq[0] == expected) begin
                  out_status_next = rsrb_pkg::ST_IN_ORDER;
                end else begin
                  out_status_next = rsrb_pkg::ST_LOSS;
                  out_lost_next   = cell_seq[0] - expected;
                  lost_total_next = lost_total + {16'd0, cell_seq[0] - expected};
                end
                expected_next = cell_seq[0] + 16'd1;
              end
            end
            rsrb_pkg::OP_FLUSH: begin
              out_status_next = rsrb_pkg::ST_FLUSHED;
              fill_next       = '0;
              expected_next   = '0;
              seen_first_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = rsrb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rsrb_pkg::S_IDLE;
      fill       <= '0;
      expected   <= '0;
      seen_first <= 1'b0;
      lost_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      expected   <= expected_next;
      seen_first <= seen_first_next;
      lost_total <= lost_total_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      op      <= request.opcode;
      key     <= request.seq_num;
      key_tag <= request.tag;
    end
    out_status <= out_status_next;
    out_seq    <= out_seq_next;
    out_tag    <= out_tag_next;
    out_lost   <= out_lost_next;
  end

endmodule

`default_nettype wire

// ===== design/rsrb_checker.sv =====
// Port-level checks for the RTP sequence reorder buffer, bound to the top.
// Depends on rsrb_pkg and rtp_sequence_reorder_buffer_unit.
`timescale 1ns / 1ps
`default_nettype none

module rsrb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] out_seq_num,
  input wire logic [15:0] out_tag,
  input wire logic [15:0] lost_count,
  input wire logic [31:0] lost_total_out
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(lost_total_out))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in progress");

  a_non_pop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == rsrb_pkg::ST_INSERTED || status == rsrb_pkg::ST_DUPLICATE ||
                  status == rsrb_pkg::ST_FULL || status == rsrb_pkg::ST_EMPTY ||
                  status == rsrb_pkg::ST_FLUSHED)
    |-> out_seq_num == 16'd0 && out_tag == 16'd0 && lost_count == 16'd0)
    else $error("pop fields set on a non-pop result");

  a_in_order_no_loss: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == rsrb_pkg::ST_IN_ORDER |-> lost_count == 16'd0)
    else $error("in-order pop reports a gap");

  a_loss_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == rsrb_pkg::ST_LOSS |-> lost_count != 16'd0)
    else $error("loss pop reports no gap");

endmodule

bind rtp_sequence_reorder_buffer_unit rsrb_checker u_rsrb_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (request.valid),
  .req_ready      (request.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .status         (result.status),
  .out_seq_num    (result.out_seq_num),
  .out_tag        (result.out_tag),
  .lost_count     (result.lost_count),
  .lost_total_out (result.lost_total_out)
);

`default_nettype wire
